FILE: sv/rte_pkg.sv
// Package for the RRT tree-extension engine: sizes, codes, state encoding
// and the control struct of the shared iterative unit. No dependencies.
package rte_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int NODE_CW   = NODE_AW + 1;
  localparam int MAX_OBST  = 64;
  localparam int OBST_AW   = (MAX_OBST > 1) ? $clog2(MAX_OBST) : 1;
  localparam int OBST_CW   = $clog2(MAX_OBST + 1);

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_OBST    = 2'd1;
  localparam logic [1:0] ACT_EXTEND  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;  // unused code, answered with ST_DONE and no table change

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_GOAL     = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_TREEFULL = 3'd4;
  localparam logic [2:0] ST_OBSTFULL = 3'd5;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_GOAL_X  = 3'd2;
  localparam logic [2:0] REG_GOAL_Y  = 3'd3;
  localparam logic [2:0] REG_RADIUS  = 3'd4;
  localparam logic [2:0] REG_STEP    = 3'd5;
  localparam logic [2:0] REG_TOL     = 3'd6;

  localparam int ITER_STEPS = 32;
  localparam int ITER_CW    = $clog2(ITER_STEPS);

  typedef enum logic {ITER_SQRT, ITER_DIV} iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_NRD, S_NDIF, S_NSQX, S_NSQY, S_NCMP,
    S_BRD, S_BDIF, S_NORM,
    S_LSQX, S_LSQY, S_LSQRT, S_LWAIT,
    S_OXM, S_OXD, S_OXW, S_OYM, S_OYD, S_OYW,
    S_SAT, S_ORD, S_OCMP, S_DEC,
    S_GSQX, S_GSQY, S_GSQR, S_GCMP,
    S_DONE
  } state_t;

endpackage

FILE: sv/rte_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
module rte_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

FILE: sv/rte_iter.sv
// Shared bit-serial unit: integer square root of 64 bits or 64/32 division
// with a 32-bit quotient, one result bit per cycle. Uses rte_pkg.
module rte_iter (
  input  logic               clk,
  input  logic               rst,
  input  rte_pkg::iter_ctl_t ctl,
  input  logic [63:0]        num,
  input  logic [31:0]        den,
  output logic               busy,
  output logic               done,
  output logic [31:0]        res
);

  rte_pkg::iter_mode_e             mode;
  logic [rte_pkg::ITER_CW-1:0]     cnt;
  logic [35:0]                     rem;
  logic [63:0]                     sh;
  logic [35:0]                     cand;
  logic [35:0]                     trial;
  logic                            ge;

  always_comb begin
    if (mode == rte_pkg::ITER_SQRT) begin
      cand  = {rem[33:0], sh[63:62]};
      trial = {2'b00, res, 2'b01};
    end else begin
      cand  = {rem[34:0], sh[63]};
      trial = {4'b0000, den};
    end
    ge = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode <= ctl.mode;
      cnt  <= rte_pkg::ITER_CW'(rte_pkg::ITER_STEPS - 1);
      res  <= '0;
      if (ctl.mode == rte_pkg::ITER_SQRT) begin
        rem <= '0;
        sh  <= num;
      end else begin
        rem <= {4'b0000, num[63:32]};
        sh  <= {num[31:0], 32'h0};
      end
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? (cand - trial) : cand;
      res <= {res[30:0], ge};
      sh  <= (mode == rte_pkg::ITER_SQRT) ? {sh[61:0], 2'b00} : {sh[62:0], 1'b0};
    end
  end

endmodule

FILE: sv/rrt_tree_extend.sv
// RRT tree extension: sequencer, node/obstacle memories and config registers.
// Uses rte_pkg, rte_mul (shared multiplier) and rte_iter (sqrt/divide unit).
//
// Restart and obstacle load pass from dispatch straight to the result stage.
// An extend takes longer as tree_count and obst_count grow and as the
// normalization shift runs longer; a sample straight above or below its
// nearest node skips the square root and both divides. The node scan (one
// shared multiplier, one memory read port) and two 32-step divides plus a
// 32-step square root set the time. One item is in flight at a time.
// Reset (synchronous, rst high) empties both tables by clearing their counts
// and restores the register defaults; there is no memory clearing pass.
module rrt_tree_extend (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x[31:0], point_y[63:32]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata    // status[2:0], new_x[34:3], new_y[66:35],
                                 // new_index[76:67], parent_index[86:77], 0
);

  localparam int NAW = rte_pkg::NODE_AW;
  localparam int NCW = rte_pkg::NODE_CW;
  localparam int OAW = rte_pkg::OBST_AW;
  localparam int OCW = rte_pkg::OBST_CW;

  // configuration
  logic signed [31:0] start_x, start_y, goal_x, goal_y;
  logic [30:0]        goal_radius, step_length;
  logic [15:0]        obst_tol;

  // memories
  logic [31:0]    tree_x   [rte_pkg::MAX_NODES];
  logic [31:0]    tree_y   [rte_pkg::MAX_NODES];
  logic [NAW-1:0] tree_par [rte_pkg::MAX_NODES];
  logic [31:0]    obst_x   [rte_pkg::MAX_OBST];
  logic [31:0]    obst_y   [rte_pkg::MAX_OBST];
  logic [31:0]    tree_rx, tree_ry, obst_rx, obst_ry;

  logic           tree_we, obst_we;
  logic [NAW-1:0] tree_waddr, tree_raddr;
  logic [31:0]    tree_wx, tree_wy;
  logic [NAW-1:0] tree_wp;
  logic [OAW-1:0] obst_waddr, obst_raddr;

  logic [NCW-1:0] tree_count;
  logic [OCW-1:0] obst_count;

  rte_pkg::state_t state, state_next;

  // captured transaction
  logic [1:0]         act;
  logic signed [31:0] px, py;

  // working registers
  logic [NAW-1:0] node_i, best;
  logic [OAW-1:0] obst_i;
  logic [64:0]    best_d, acc;
  logic [31:0]    ax, ay, len, offx, offy, gdx, gdy;
  logic signed [31:0] bx, by;
  logic           hit;

  // result
  logic [2:0]         res_status;
  logic signed [31:0] res_x, res_y;
  logic [NAW-1:0]     res_idx, res_par;

  // shared units
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  rte_pkg::iter_ctl_t ictl;
  logic [63:0]        inum;
  logic               ibusy, idone;
  logic [31:0]        ires;

  rte_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  rte_iter u_iter (
    .clk(clk), .rst(rst), .ctl(ictl), .num(inum), .den(len),
    .busy(ibusy), .done(idone), .res(ires)
  );

  // helpers
  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic signed [31:0] step_sat(input logic signed [31:0] base,
                                                  input logic [31:0] off,
                                                  input logic add);
    logic signed [33:0] s;
    s = add ? (34'(base) + $signed({2'b00, off})) : (34'(base) - $signed({2'b00, off}));
    if (s > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  logic [31:0] ndx, ndy, mmax;
  logic [64:0] node_d;
  logic        ohit;

  assign ndx    = absdiff($signed(tree_rx), px);
  assign ndy    = absdiff($signed(tree_ry), py);
  assign node_d = acc + 65'(prod);
  assign mmax   = (ax > ay) ? ax : ay;
  assign ohit   = (absdiff($signed(obst_rx), res_x) < 32'(obst_tol)) &&
                  (absdiff($signed(obst_ry), res_y) < 32'(obst_tol));

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_x[tree_waddr]   <= tree_wx;
      tree_y[tree_waddr]   <= tree_wy;
      tree_par[tree_waddr] <= tree_wp;
    end
    tree_rx <= tree_x[tree_raddr];
    tree_ry <= tree_y[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (obst_we) begin
      obst_x[obst_waddr] <= px;
      obst_y[obst_waddr] <= py;
    end
    obst_rx <= obst_x[obst_raddr];
    obst_ry <= obst_y[obst_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      goal_radius <= 31'd262144;
      step_length <= 31'd65536;
      obst_tol    <= 16'd7;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rte_pkg::REG_START_X: start_x     <= cfg_wdata;
        rte_pkg::REG_START_Y: start_y     <= cfg_wdata;
        rte_pkg::REG_GOAL_X:  goal_x      <= cfg_wdata;
        rte_pkg::REG_GOAL_Y:  goal_y      <= cfg_wdata;
        rte_pkg::REG_RADIUS:  goal_radius <= cfg_wdata[30:0];
        rte_pkg::REG_STEP:    step_length <= cfg_wdata[30:0];
        rte_pkg::REG_TOL:     obst_tol    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rte_pkg::S_IDLE: if (s_tvalid) state_next = rte_pkg::S_DISP;
      rte_pkg::S_DISP: begin
        if (act == rte_pkg::ACT_EXTEND && tree_count != '0) begin
          state_next = rte_pkg::S_NRD;
        end else begin
          state_next = rte_pkg::S_DONE;
        end
      end
      rte_pkg::S_NRD:  state_next = rte_pkg::S_NDIF;
      rte_pkg::S_NDIF: state_next = rte_pkg::S_NSQX;
      rte_pkg::S_NSQX: state_next = rte_pkg::S_NSQY;
      rte_pkg::S_NSQY: state_next = rte_pkg::S_NCMP;
      rte_pkg::S_NCMP: begin
        if (NCW'(node_i) + 1'b1 == tree_count) state_next = rte_pkg::S_BRD;
        else state_next = rte_pkg::S_NRD;
      end
      rte_pkg::S_BRD:  state_next = rte_pkg::S_BDIF;
      rte_pkg::S_BDIF: begin
        if (ndx == '0) state_next = rte_pkg::S_SAT;
        else state_next = rte_pkg::S_NORM;
      end
      rte_pkg::S_NORM: if (mmax[31:30] == 2'b01) state_next = rte_pkg::S_LSQX;
      rte_pkg::S_LSQX:  state_next = rte_pkg::S_LSQY;
      rte_pkg::S_LSQY:  state_next = rte_pkg::S_LSQRT;
      rte_pkg::S_LSQRT: state_next = rte_pkg::S_LWAIT;
      rte_pkg::S_LWAIT: if (idone) state_next = rte_pkg::S_OXM;
      rte_pkg::S_OXM:   state_next = rte_pkg::S_OXD;
      rte_pkg::S_OXD:   state_next = rte_pkg::S_OXW;
      rte_pkg::S_OXW:   if (idone) state_next = rte_pkg::S_OYM;
      rte_pkg::S_OYM:   state_next = rte_pkg::S_OYD;
      rte_pkg::S_OYD:   state_next = rte_pkg::S_OYW;
      rte_pkg::S_OYW:   if (idone) state_next = rte_pkg::S_SAT;
      rte_pkg::S_SAT: begin
        if (obst_count == '0) state_next = rte_pkg::S_DEC;
        else state_next = rte_pkg::S_ORD;
      end
      rte_pkg::S_ORD:  state_next = rte_pkg::S_OCMP;
      rte_pkg::S_OCMP: begin
        if (ohit || OCW'(obst_i) + 1'b1 == obst_count) state_next = rte_pkg::S_DEC;
        else state_next = rte_pkg::S_ORD;
      end
      rte_pkg::S_DEC: begin
        if (hit || tree_count >= NCW'(rte_pkg::MAX_NODES)) state_next = rte_pkg::S_DONE;
        else state_next = rte_pkg::S_GSQX;
      end
      rte_pkg::S_GSQX: state_next = rte_pkg::S_GSQY;
      rte_pkg::S_GSQY: state_next = rte_pkg::S_GSQR;
      rte_pkg::S_GSQR: state_next = rte_pkg::S_GCMP;
      rte_pkg::S_GCMP: state_next = rte_pkg::S_DONE;
      rte_pkg::S_DONE: if (!m_tvalid || m_tready) state_next = rte_pkg::S_IDLE;
      default: state_next = rte_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = (state == rte_pkg::S_IDLE);
    tree_raddr = node_i;
    obst_raddr = obst_i;
    mul_a      = ax;
    mul_b      = ax;
    ictl.start = 1'b0;
    ictl.mode  = rte_pkg::ITER_SQRT;
    inum       = acc[63:0] + prod;
    tree_we    = 1'b0;
    tree_waddr = '0;
    tree_wx    = start_x;
    tree_wy    = start_y;
    tree_wp    = '0;
    obst_we    = 1'b0;
    obst_waddr = obst_count[OAW-1:0];
    unique case (state)
      rte_pkg::S_DISP: begin
        tree_we = (act == rte_pkg::ACT_RESTART);
        obst_we = (act == rte_pkg::ACT_OBST) && (obst_count < OCW'(rte_pkg::MAX_OBST));
      end
      rte_pkg::S_NSQX, rte_pkg::S_LSQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      rte_pkg::S_NSQY, rte_pkg::S_LSQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      rte_pkg::S_BRD: tree_raddr = best;
      rte_pkg::S_LSQRT: ictl.start = 1'b1;
      rte_pkg::S_OXM: begin
        mul_a = {1'b0, step_length};
        mul_b = ax;
      end
      rte_pkg::S_OYM: begin
        mul_a = {1'b0, step_length};
        mul_b = ay;
      end
      rte_pkg::S_OXD, rte_pkg::S_OYD: begin
        ictl.start = 1'b1;
        ictl.mode  = rte_pkg::ITER_DIV;
        inum       = prod + {33'h0, len[31:1]};
      end
      rte_pkg::S_DEC: begin
        tree_we    = !hit && (tree_count < NCW'(rte_pkg::MAX_NODES));
        tree_waddr = tree_count[NAW-1:0];
        tree_wx    = res_x;
        tree_wy    = res_y;
        tree_wp    = best;
      end
      rte_pkg::S_GSQX: begin
        mul_a = gdx;
        mul_b = gdx;
      end
      rte_pkg::S_GSQY: begin
        mul_a = gdy;
        mul_b = gdy;
      end
      rte_pkg::S_GSQR: begin
        mul_a = {1'b0, goal_radius};
        mul_b = {1'b0, goal_radius};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rte_pkg::S_IDLE;
    else state <= state_next;
  end

  // counts and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_count <= '0;
      obst_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == rte_pkg::S_DISP && act == rte_pkg::ACT_RESTART) begin
        tree_count <= NCW'(1);
        obst_count <= '0;
      end
      if (obst_we) obst_count <= obst_count + 1'b1;
      if (state == rte_pkg::S_DEC && tree_we) tree_count <= tree_count + 1'b1;
      if (state == rte_pkg::S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rte_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, 10'(res_par), 10'(res_idx), res_y, res_x, res_status};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rte_pkg::S_IDLE: begin
        act        <= s_tuser;
        px         <= s_tdata[31:0];
        py         <= s_tdata[63:32];
        node_i     <= '0;
        obst_i     <= '0;
        hit        <= 1'b0;
        res_status <= rte_pkg::ST_DONE;
        res_x      <= '0;
        res_y      <= '0;
        res_idx    <= '0;
        res_par    <= '0;
      end
      rte_pkg::S_DISP: begin
        if (act == rte_pkg::ACT_RESTART) begin
          res_x <= start_x;
          res_y <= start_y;
        end
        if (act == rte_pkg::ACT_OBST && obst_count >= OCW'(rte_pkg::MAX_OBST)) begin
          res_status <= rte_pkg::ST_OBSTFULL;
        end
      end
      rte_pkg::S_NDIF: begin
        ax <= ndx;
        ay <= ndy;
      end
      rte_pkg::S_NSQY: acc <= 65'(prod);
      rte_pkg::S_NCMP: begin
        if (node_i == '0 || node_d < best_d) begin
          best_d <= node_d;
          best   <= node_i;
        end
        node_i <= node_i + 1'b1;
      end
      rte_pkg::S_BDIF: begin
        bx   <= tree_rx;
        by   <= tree_ry;
        ax   <= ndx;
        ay   <= ndy;
        offx <= '0;
        offy <= {1'b0, step_length};
      end
      rte_pkg::S_NORM: begin
        if (mmax[31]) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (!mmax[30]) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      rte_pkg::S_LSQY: acc <= 65'(prod);
      rte_pkg::S_LWAIT: if (idone) len <= ires;
      rte_pkg::S_OXW: if (idone) offx <= ires;
      rte_pkg::S_OYW: if (idone) offy <= ires;
      rte_pkg::S_SAT: begin
        res_x   <= step_sat(bx, offx, goal_x >= bx);
        res_y   <= step_sat(by, offy, goal_y >= by);
        res_par <= best;
      end
      rte_pkg::S_OCMP: begin
        hit    <= ohit;
        obst_i <= obst_i + 1'b1;
      end
      rte_pkg::S_DEC: begin
        gdx <= absdiff(res_x, goal_x);
        gdy <= absdiff(res_y, goal_y);
        if (hit) begin
          res_status <= rte_pkg::ST_BLOCKED;
        end else if (tree_count >= NCW'(rte_pkg::MAX_NODES)) begin
          res_status <= rte_pkg::ST_TREEFULL;
        end else begin
          res_status <= rte_pkg::ST_ADDED;
          res_idx    <= tree_count[NAW-1:0];
        end
      end
      rte_pkg::S_GSQY: acc <= 65'(prod);
      rte_pkg::S_GSQR: acc <= acc + 65'(prod);
      rte_pkg::S_GCMP: begin
        // both components inside the radius keep the squares below 2^62
        if (gdx < 32'(goal_radius) && gdy < 32'(goal_radius) && acc < 65'(prod)) begin
          res_status <= rte_pkg::ST_GOAL;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_tree_bound: assert property (@(posedge clk) disable iff (rst)
    tree_count <= NCW'(rte_pkg::MAX_NODES))
    else $error("tree count beyond table size");
  a_obst_bound: assert property (@(posedge clk) disable iff (rst)
    obst_count <= OCW'(rte_pkg::MAX_OBST))
    else $error("obstacle count beyond table size");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");
  a_iter_free: assert property (@(posedge clk) disable iff (rst)
    ictl.start |-> !ibusy)
    else $error("iterative unit restarted while busy");
  a_tree_write: assert property (@(posedge clk) disable iff (rst)
    tree_we |-> (state == rte_pkg::S_DISP || !hit))
    else $error("node stored after obstacle hit");
`endif

endmodule
